@@ hw/rtl/rmqb_pkg.sv @@
// Shared types and constants for the routed multi-queue bank.
// Holds result kind codes, command codes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package rmqb_pkg;

  // Fixed payload widths
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned QIDX_W = 4;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned REM_W  = 16;

  // Admit limit after reset
  localparam logic [VAL_W-1:0] ADMIT_LIMIT_RST = 8'd10;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_POP  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

endpackage

@@ hw/rtl/routed_multi_queue_bank_top.sv @@
// Top level of the routed multi-queue bank: queue-state memory, entry memory, control.
// Depends on rmqb_pkg.
//
//   channel   | handshake           | payload
//   ----------+---------------------+------------------------------------------------
//   input     | start, busy         | in_cmd, in_queue_index, in_value
//   result    | out_strobe          | out_kind, out_queue, out_value, out_accepted,
//             |                     | out_occupancy, out_removed_total, out_last
//   config    | cfg_we              | cfg_wdata (admit limit)
//
// An insert reads the queue-state memory, then updates the state and writes it back.
// A drain with no small queue occupied returns a single none result; otherwise, for each
// occupied small queue in turn, it reads the queue state, then the entry memory, and emits
// one pop result.
// Reset is synchronous; per-queue valid bits make the queue state read as zero until
// first written, so no clearing pass is needed. The receiver cannot stall results.
`timescale 1ns / 1ps

module routed_multi_queue_bank_top #(
  parameter int unsigned NUM_QUEUES  = 10,
  parameter int unsigned SMALL_DEPTH = 16,
  parameter int unsigned BIG_DEPTH   = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [rmqb_pkg::QIDX_W-1:0]         in_queue_index,
  input  logic [rmqb_pkg::VAL_W-1:0]          in_value,
  // result channel
  output logic                                out_strobe,
  output rmqb_pkg::kind_t                     out_kind,
  output logic [rmqb_pkg::QIDX_W-1:0]         out_queue,
  output logic [rmqb_pkg::VAL_W-1:0]          out_value,
  output logic                                out_accepted,
  output logic [rmqb_pkg::OCC_W-1:0]          out_occupancy,
  output logic [rmqb_pkg::REM_W-1:0]          out_removed_total,
  output logic                                out_last,
  // configuration
  input  logic                                cfg_we,
  input  logic [rmqb_pkg::VAL_W-1:0]          cfg_wdata
);

  import rmqb_pkg::*;

  localparam int unsigned MAXD    = (BIG_DEPTH > SMALL_DEPTH) ? BIG_DEPTH : SMALL_DEPTH;
  localparam int unsigned QW      = $clog2(NUM_QUEUES);
  localparam int unsigned HW      = $clog2(MAXD);
  localparam int unsigned CW      = $clog2(MAXD + 1);
  localparam int unsigned STORE_N = (NUM_QUEUES - 1) * SMALL_DEPTH + BIG_DEPTH;
  localparam int unsigned AW      = $clog2(STORE_N);
  localparam int unsigned QS_W    = HW + CW + REM_W;

  localparam logic [NUM_QUEUES-1:0] SMALL_MASK = {1'b0, {(NUM_QUEUES-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_DRQ  = 4'b0100,
    S_DRE  = 4'b1000
  } state_t;

  // Lowest set bit of a queue mask
  function automatic logic [QW-1:0] first_set(input logic [NUM_QUEUES-1:0] v);
    logic [QW-1:0] idx;
    idx = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (v[i]) idx = QW'(i);
    end
    return idx;
  endfunction

  // Control and holding registers
  state_t                  state_r, state_nxt;
  logic [QW-1:0]           q_r, q_nxt;
  logic [QIDX_W-1:0]       iq_r, iq_nxt;
  logic                    inr_r, inr_nxt;
  logic [VAL_W-1:0]        val_r, val_nxt;
  logic [NUM_QUEUES-1:0]   pend_r, pend_nxt;
  logic [NUM_QUEUES-1:0]   nemp_r, nemp_nxt;
  logic [VAL_W-1:0]        limit_r;
  logic [CW-1:0]           hold_cnt_r, hold_cnt_nxt;
  logic [REM_W-1:0]        hold_rem_r, hold_rem_nxt;

  // Result registers
  logic                    out_strobe_r, out_strobe_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  logic [QIDX_W-1:0]       out_queue_r, out_queue_nxt;
  logic [VAL_W-1:0]        out_value_r, out_value_nxt;
  logic                    out_acc_r, out_acc_nxt;
  logic [OCC_W-1:0]        out_occ_r, out_occ_nxt;
  logic [REM_W-1:0]        out_rem_r, out_rem_nxt;
  logic                    out_last_r, out_last_nxt;

  // Queue-state memory: {head, count, removed} per queue
  logic [QS_W-1:0]         qs_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]   qs_vld_r;
  logic [QS_W-1:0]         qs_rdata_r;
  logic                    qs_rvld_r;
  logic                    qs_re, qs_we;
  logic [QW-1:0]           qs_raddr, qs_waddr;
  logic [QS_W-1:0]         qs_wdata;

  // Entry memory
  logic [VAL_W-1:0]        st_mem [STORE_N];
  logic [VAL_W-1:0]        st_rdata_r;
  logic                    st_re, st_we;
  logic [AW-1:0]           st_raddr, st_waddr;
  logic [VAL_W-1:0]        st_wdata;

  // Decoded queue state; unwritten entries read as zero
  logic [HW-1:0]           rd_head;
  logic [CW-1:0]           rd_cnt;
  logic [REM_W-1:0]        rd_rem;

  assign rd_head = qs_rvld_r ? qs_rdata_r[QS_W-1 -: HW]      : '0;
  assign rd_cnt  = qs_rvld_r ? qs_rdata_r[REM_W +: CW]       : '0;
  assign rd_rem  = qs_rvld_r ? qs_rdata_r[REM_W-1:0]         : '0;

  // Insert arithmetic
  logic [CW-1:0]           dep;
  logic                    is_big;
  logic                    admit;
  logic [CW:0]             slot_sum;
  logic [CW:0]             slot_w;
  logic [HW-1:0]           slot;
  logic [CW-1:0]           ins_cnt;

  assign is_big   = (q_r == QW'(NUM_QUEUES - 1));
  assign dep      = is_big ? CW'(BIG_DEPTH) : CW'(SMALL_DEPTH);
  assign admit    = inr_r && (rd_cnt < dep) && (is_big || (val_r <= limit_r));
  assign slot_sum = (CW+1)'(rd_head) + (CW+1)'(rd_cnt);
  assign slot_w   = (slot_sum >= (CW+1)'(dep)) ? slot_sum - (CW+1)'(dep) : slot_sum;
  assign slot     = HW'(slot_w);
  assign ins_cnt  = rd_cnt + CW'(admit);

  // Pop arithmetic
  logic [HW-1:0]           pop_head;
  logic [CW-1:0]           pop_cnt;
  logic [REM_W-1:0]        pop_rem;

  assign pop_head = (rd_head == HW'(SMALL_DEPTH - 1)) ? '0 : rd_head + 1'b1;
  assign pop_cnt  = rd_cnt - 1'b1;
  assign pop_rem  = (rd_rem == {REM_W{1'b1}}) ? rd_rem : rd_rem + 1'b1;

  assign busy = (state_r != S_IDLE);

  // Sequence inserts and drain walks
  always_comb begin
    logic [NUM_QUEUES-1:0] pick;
    logic [QW-1:0]         idx;
    pick = '0;
    idx  = '0;

    state_nxt      = state_r;
    q_nxt          = q_r;
    iq_nxt         = iq_r;
    inr_nxt        = inr_r;
    val_nxt        = val_r;
    pend_nxt       = pend_r;
    nemp_nxt       = nemp_r;
    hold_cnt_nxt   = hold_cnt_r;
    hold_rem_nxt   = hold_rem_r;

    out_strobe_nxt = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_queue_nxt  = out_queue_r;
    out_value_nxt  = out_value_r;
    out_acc_nxt    = out_acc_r;
    out_occ_nxt    = out_occ_r;
    out_rem_nxt    = out_rem_r;
    out_last_nxt   = out_last_r;

    qs_re    = 1'b0;
    qs_raddr = q_r;
    qs_we    = 1'b0;
    qs_waddr = q_r;
    qs_wdata = '0;
    st_re    = 1'b0;
    st_raddr = '0;
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_INSERT) begin
            // latch the insert and fetch its queue state
            q_nxt     = QW'(in_queue_index);
            iq_nxt    = in_queue_index;
            inr_nxt   = (32'(in_queue_index) < NUM_QUEUES);
            val_nxt   = in_value;
            qs_re     = inr_nxt;
            qs_raddr  = QW'(in_queue_index);
            state_nxt = S_INS;
          end else begin
            pick = nemp_r & SMALL_MASK;
            if (pick == '0) begin
              // nothing to pop: single "none" result
              out_strobe_nxt = 1'b1;
              out_kind_nxt   = KIND_NONE;
              out_queue_nxt  = '0;
              out_value_nxt  = '0;
              out_acc_nxt    = 1'b0;
              out_occ_nxt    = '0;
              out_rem_nxt    = '0;
              out_last_nxt   = 1'b1;
            end else begin
              idx       = first_set(pick);
              pick[idx] = 1'b0;
              pend_nxt  = pick;
              q_nxt     = idx;
              qs_re     = 1'b1;
              qs_raddr  = idx;
              state_nxt = S_DRQ;
            end
          end
        end
      end

      S_INS: begin
        // store the value and write back the count when admitted
        if (admit) begin
          qs_we        = 1'b1;
          qs_wdata     = {rd_head, ins_cnt, rd_rem};
          st_we        = 1'b1;
          st_waddr     = AW'(q_r) * AW'(SMALL_DEPTH) + AW'(slot);
          nemp_nxt[q_r] = 1'b1;
        end
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_ACK;
        out_queue_nxt  = iq_r;
        out_value_nxt  = val_r;
        out_acc_nxt    = admit;
        out_occ_nxt    = inr_r ? OCC_W'(ins_cnt) : '0;
        out_rem_nxt    = inr_r ? rd_rem : '0;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_DRQ: begin
        // advance head, write back state, fetch the head entry
        qs_we        = 1'b1;
        qs_wdata     = {pop_head, pop_cnt, pop_rem};
        st_re        = 1'b1;
        st_raddr     = AW'(q_r) * AW'(SMALL_DEPTH) + AW'(rd_head);
        hold_cnt_nxt = pop_cnt;
        hold_rem_nxt = pop_rem;
        if (pop_cnt == '0) nemp_nxt[q_r] = 1'b0;
        state_nxt    = S_DRE;
      end

      S_DRE: begin
        // emit the popped entry, then move on to the next occupied queue
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_POP;
        out_queue_nxt  = QIDX_W'(q_r);
        out_value_nxt  = st_rdata_r;
        out_acc_nxt    = 1'b0;
        out_occ_nxt    = OCC_W'(hold_cnt_r);
        out_rem_nxt    = hold_rem_r;
        out_last_nxt   = (pend_r == '0);
        if (pend_r != '0) begin
          pick      = pend_r;
          idx       = first_set(pick);
          pick[idx] = 1'b0;
          pend_nxt  = pick;
          q_nxt     = idx;
          qs_re     = 1'b1;
          qs_raddr  = idx;
          state_nxt = S_DRQ;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= '0;
      nemp_r       <= '0;
      limit_r      <= ADMIT_LIMIT_RST;
      qs_vld_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      nemp_r       <= nemp_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      if (qs_we) qs_vld_r[qs_waddr] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    iq_r        <= iq_nxt;
    inr_r       <= inr_nxt;
    val_r       <= val_nxt;
    hold_cnt_r  <= hold_cnt_nxt;
    hold_rem_r  <= hold_rem_nxt;
    out_kind_r  <= out_kind_nxt;
    out_queue_r <= out_queue_nxt;
    out_value_r <= out_value_nxt;
    out_acc_r   <= out_acc_nxt;
    out_occ_r   <= out_occ_nxt;
    out_rem_r   <= out_rem_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Queue-state memory, registered read
  always_ff @(posedge clk) begin
    if (qs_we) qs_mem[qs_waddr] <= qs_wdata;
    if (qs_re) begin
      qs_rdata_r <= qs_mem[qs_raddr];
      qs_rvld_r  <= qs_vld_r[qs_raddr];
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_rdata_r <= st_mem[st_raddr];
  end

  assign out_strobe        = out_strobe_r;
  assign out_kind          = out_kind_r;
  assign out_queue         = out_queue_r;
  assign out_value         = out_value_r;
  assign out_accepted      = out_acc_r;
  assign out_occupancy     = out_occ_r;
  assign out_removed_total = out_rem_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  // Pending mask is only live during a drain walk
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_INS) |-> pend_r == '0)
    else $error("pending drain mask set outside a drain");

  // A non-final pop is followed by a gap without a strobe, then by the next pop
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> !out_strobe ##1 out_strobe)
    else $error("drain results not spaced as expected");

  // Popped entries always carry a nonzero removal count
  a_pop_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_POP) |-> out_removed_total != '0)
    else $error("pop reported with zero removal count");

  // The large queue is never drained
  a_pop_small: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_POP) |-> out_queue != QIDX_W'(NUM_QUEUES - 1))
    else $error("pop reported from the large queue");
`endif

endmodule
